/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/i80_pkg.sv */
// Shared types, codes and the microcode table of the 8080 display bus master.
// No dependencies.
package i80_pkg;

    localparam int READ_LIMIT = 16;
    localparam int MAX_FILL   = 64;

    localparam int OP_W  = 3;
    localparam int CNT_W = 7;
    localparam int RD_W  = 5;
    localparam int PC_W  = 5;

    localparam logic [OP_W-1:0] OP_BEGIN  = 3'd0;
    localparam logic [OP_W-1:0] OP_WBYTE  = 3'd1;
    localparam logic [OP_W-1:0] OP_WWORD  = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd3;
    localparam logic [OP_W-1:0] OP_BITMAP = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;
    localparam logic [OP_W-1:0] OP_END    = 3'd6;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_DUMMY = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_LIMIT = 2'd1;
    localparam logic [1:0] STAT_NOSEL = 2'd2;

    localparam logic CFG_OFF_COLOR = 1'b0;
    localparam logic CFG_ON_COLOR  = 1'b1;

    localparam logic [PC_W-1:0] A_BEGIN  = 5'd0;
    localparam logic [PC_W-1:0] A_END    = 5'd1;
    localparam logic [PC_W-1:0] A_UNUSED = 5'd2;
    localparam logic [PC_W-1:0] A_NOSEL  = 5'd3;
    localparam logic [PC_W-1:0] A_WB0    = 5'd4;
    localparam logic [PC_W-1:0] A_WB1    = 5'd5;
    localparam logic [PC_W-1:0] A_WW0    = 5'd6;
    localparam logic [PC_W-1:0] A_WW1    = 5'd7;
    localparam logic [PC_W-1:0] A_F0     = 5'd8;
    localparam logic [PC_W-1:0] A_F1     = 5'd9;
    localparam logic [PC_W-1:0] A_F2     = 5'd10;
    localparam logic [PC_W-1:0] A_FILLZ  = 5'd11;
    localparam logic [PC_W-1:0] A_B0     = 5'd12;
    localparam logic [PC_W-1:0] A_B1     = 5'd13;
    localparam logic [PC_W-1:0] A_R0     = 5'd14;
    localparam logic [PC_W-1:0] A_R1     = 5'd15;
    localparam logic [PC_W-1:0] A_R2     = 5'd16;
    localparam logic [PC_W-1:0] A_R3     = 5'd17;
    localparam logic [PC_W-1:0] A_R4     = 5'd18;
    localparam logic [PC_W-1:0] A_RLIM   = 5'd19;

    typedef enum logic [2:0] {
        C_NONE, C_NOSEL, C_CNT_ZERO, C_CNT_MORE, C_LIMIT, C_NO_DUMMY
    } t_cond;

    typedef enum logic [1:0] {B_ZERO, B_PAY_LO, B_PAY_WORD, B_COLOR} t_bus;
    typedef enum logic [1:0] {S_KEEP, S_SET, S_CLR} t_sel;
    typedef enum logic [1:0] {K_KEEP, K_FILL, K_EIGHT, K_DEC} t_cnt;

    typedef struct packed {
        logic            emit;
        logic            done;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            dnc;
        logic [1:0]      strobe;
        t_bus            bus;
        logic            wide;
        logic            rd;
        logic [1:0]      status;
        t_sel            sel;
        logic            arm;
        logic            clr_dummy;
        logic            clr_reads;
        logic            inc_reads;
        t_cnt            cnt;
    } t_cw;

    typedef struct packed {
        logic accept;
        logic fire;
        logic taken;
        t_cw  cw;
    } t_ctl;

    typedef struct packed {
        logic nosel;
        logic cnt_zero;
        logic cnt_more;
        logic limit;
        logic no_dummy;
        logic out_free;
    } t_flags;

    function automatic logic [PC_W-1:0] entry(input logic [OP_W-1:0] op);
        logic [PC_W-1:0] a;
        unique case (op)
            OP_BEGIN:  a = A_BEGIN;
            OP_WBYTE:  a = A_WB0;
            OP_WWORD:  a = A_WW0;
            OP_FILL:   a = A_F0;
            OP_BITMAP: a = A_B0;
            OP_READ:   a = A_R0;
            OP_END:    a = A_END;
            default:   a = A_UNUSED;
        endcase
        return a;
    endfunction

    function automatic t_cw ucode(input logic [PC_W-1:0] a);
        t_cw c;
        c     = '0;
        c.dnc = 1'b1;
        unique case (a)
            A_BEGIN: begin
                c.emit = 1'b1; c.done = 1'b1; c.dnc = 1'b0;
                c.strobe = ST_WRITE; c.bus = B_PAY_LO;
                c.sel = S_SET; c.arm = 1'b1; c.clr_reads = 1'b1;
            end
            A_END: begin
                c.emit = 1'b1; c.done = 1'b1;
                c.sel = S_CLR; c.clr_dummy = 1'b1; c.clr_reads = 1'b1;
            end
            A_UNUSED, A_FILLZ: begin
                c.emit = 1'b1; c.done = 1'b1;
            end
            A_NOSEL: begin
                c.emit = 1'b1; c.done = 1'b1; c.status = STAT_NOSEL;
            end
            A_WB0, A_WW0, A_R0: begin
                c.cond = C_NOSEL; c.target = A_NOSEL;
            end
            A_WB1: begin
                c.emit = 1'b1; c.done = 1'b1;
                c.strobe = ST_WRITE; c.bus = B_PAY_LO;
            end
            A_WW1: begin
                c.emit = 1'b1; c.done = 1'b1;
                c.strobe = ST_WRITE; c.bus = B_PAY_WORD; c.wide = 1'b1;
            end
            A_F0: begin
                c.cond = C_NOSEL; c.target = A_NOSEL; c.cnt = K_FILL;
            end
            A_F1: begin
                c.cond = C_CNT_ZERO; c.target = A_FILLZ;
            end
            A_F2: begin
                c.emit = 1'b1; c.done = 1'b1; c.cond = C_CNT_MORE; c.target = A_F2;
                c.strobe = ST_WRITE; c.bus = B_PAY_WORD; c.wide = 1'b1; c.cnt = K_DEC;
            end
            A_B0: begin
                c.cond = C_NOSEL; c.target = A_NOSEL; c.cnt = K_EIGHT;
            end
            A_B1: begin
                c.emit = 1'b1; c.done = 1'b1; c.cond = C_CNT_MORE; c.target = A_B1;
                c.strobe = ST_WRITE; c.bus = B_COLOR; c.wide = 1'b1; c.cnt = K_DEC;
            end
            A_R1: begin
                c.cond = C_LIMIT; c.target = A_RLIM;
            end
            A_R2: begin
                c.cond = C_NO_DUMMY; c.target = A_R4;
            end
            A_R3: begin
                c.emit = 1'b1; c.strobe = ST_DUMMY; c.clr_dummy = 1'b1;
            end
            A_R4: begin
                c.emit = 1'b1; c.done = 1'b1;
                c.strobe = ST_READ; c.rd = 1'b1; c.inc_reads = 1'b1;
            end
            A_RLIM: begin
                c.emit = 1'b1; c.done = 1'b1; c.status = STAT_LIMIT;
            end
            default: begin
                c.emit = 1'b1; c.done = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

/* src/i80_useq.sv */
// Microcode sequencer: step counter, control-word table and jump logic.
// Depends on i80_pkg.
module i80_useq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [i80_pkg::OP_W-1:0]    i_operation,
    input  i80_pkg::t_flags             i_flags,
    output logic                        o_busy,
    output i80_pkg::t_ctl               o_ctl
);

    logic [i80_pkg::PC_W-1:0] r_pc, n_pc;
    logic                     r_busy, n_busy;
    i80_pkg::t_cw             cw;
    logic                     taken;
    logic                     fire;
    logic                     accept;

    assign cw     = i80_pkg::ucode(r_pc);
    assign accept = i_in_valid && !r_busy;
    assign fire   = r_busy && (!cw.emit || i_flags.out_free);

    always_comb begin
        unique case (cw.cond)
            i80_pkg::C_NONE:     taken = 1'b0;
            i80_pkg::C_NOSEL:    taken = i_flags.nosel;
            i80_pkg::C_CNT_ZERO: taken = i_flags.cnt_zero;
            i80_pkg::C_CNT_MORE: taken = i_flags.cnt_more;
            i80_pkg::C_LIMIT:    taken = i_flags.limit;
            i80_pkg::C_NO_DUMMY: taken = i_flags.no_dummy;
            default:             taken = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        priority if (accept) begin
            n_pc   = i80_pkg::entry(i_operation);
            n_busy = 1'b1;
        end else if (fire) begin
            if (taken) begin
                n_pc = cw.target;
            end else if (cw.done) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + i80_pkg::PC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= i80_pkg::A_BEGIN;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy       = r_busy;
    assign o_ctl.accept = accept;
    assign o_ctl.fire   = fire;
    assign o_ctl.taken  = taken;
    assign o_ctl.cw     = cw;

endmodule

/* src/i80_dp.sv */
// Datapath: item latch, bus state, colour registers, counter and result register.
// Depends on i80_pkg; driven by the control word of i80_useq.
module i80_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  i80_pkg::t_ctl               i_ctl,
    input  logic [15:0]                 i_payload,
    input  logic [6:0]                  i_repeat_count,
    input  logic [7:0]                  i_bus_sample,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [15:0]                 i_cfg_wdata,
    input  logic                        i_out_stall,
    output i80_pkg::t_flags             o_flags,
    output logic                        o_out_valid,
    output logic                        o_chip_select,
    output logic                        o_data_not_command,
    output logic [1:0]                  o_strobe_res,
    output logic [15:0]                 o_bus_out,
    output logic                        o_wide_bus,
    output logic [7:0]                  o_read_value,
    output logic [1:0]                  o_status,
    output logic                        o_last
);

    logic [15:0]                r_payload;
    logic [6:0]                 r_count_in;
    logic [7:0]                 r_sample;
    logic [7:0]                 r_bits;
    logic [i80_pkg::CNT_W-1:0]  r_cnt;
    logic [15:0]                r_off_color, r_on_color;
    logic                       r_sel, r_dummy;
    logic [i80_pkg::RD_W-1:0]   r_reads;

    logic                       r_out_valid;
    logic                       r_cs, r_dnc, r_wide, r_last;
    logic [1:0]                 r_strobe, r_status;
    logic [15:0]                r_bus;
    logic [7:0]                 r_rd;

    logic                       out_free;
    logic                       emit;
    logic                       n_cs;
    logic [15:0]                n_bus;
    logic [i80_pkg::CNT_W-1:0]  fill_cnt;
    i80_pkg::t_cw               cw;

    assign cw       = i_ctl.cw;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = i_ctl.fire && cw.emit;
    assign fill_cnt = (r_count_in > i80_pkg::CNT_W'(i80_pkg::MAX_FILL))
                    ? i80_pkg::CNT_W'(i80_pkg::MAX_FILL) : r_count_in;

    always_comb begin
        unique case (cw.sel)
            i80_pkg::S_SET: n_cs = 1'b1;
            i80_pkg::S_CLR: n_cs = 1'b0;
            default:        n_cs = r_sel;
        endcase
        unique case (cw.bus)
            i80_pkg::B_ZERO:     n_bus = 16'h0000;
            i80_pkg::B_PAY_LO:   n_bus = {8'h00, r_payload[7:0]};
            i80_pkg::B_PAY_WORD: n_bus = r_payload;
            i80_pkg::B_COLOR:    n_bus = r_bits[0] ? r_on_color : r_off_color;
            default:             n_bus = 16'h0000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_payload  <= i_payload;
            r_count_in <= i_repeat_count;
            r_sample   <= i_bus_sample;
            r_bits     <= i_payload[7:0];
        end else if (i_ctl.fire && cw.cnt == i80_pkg::K_DEC) begin
            r_bits <= {1'b0, r_bits[7:1]};
        end
        if (i_ctl.fire) begin
            unique case (cw.cnt)
                i80_pkg::K_FILL:  r_cnt <= fill_cnt;
                i80_pkg::K_EIGHT: r_cnt <= i80_pkg::CNT_W'(8);
                i80_pkg::K_DEC:   r_cnt <= r_cnt - i80_pkg::CNT_W'(1);
                default:          r_cnt <= r_cnt;
            endcase
        end
        if (emit) begin
            r_cs     <= n_cs;
            r_dnc    <= cw.dnc;
            r_strobe <= cw.strobe;
            r_bus    <= n_bus;
            r_wide   <= cw.wide;
            r_rd     <= cw.rd ? r_sample : 8'h00;
            r_status <= cw.status;
            r_last   <= cw.done && !i_ctl.taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_color <= 16'h0000;
            r_on_color  <= 16'hFFFF;
            r_sel       <= 1'b0;
            r_dummy     <= 1'b0;
            r_reads     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    i80_pkg::CFG_OFF_COLOR: r_off_color <= i_cfg_wdata;
                    i80_pkg::CFG_ON_COLOR:  r_on_color  <= i_cfg_wdata;
                    default:                r_on_color  <= r_on_color;
                endcase
            end
            if (i_ctl.fire) begin
                r_sel <= n_cs;
                if (cw.arm) begin
                    r_dummy <= 1'b1;
                end else if (cw.clr_dummy) begin
                    r_dummy <= 1'b0;
                end
                if (cw.clr_reads) begin
                    r_reads <= '0;
                end else if (cw.inc_reads) begin
                    r_reads <= r_reads + i80_pkg::RD_W'(1);
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_flags.nosel    = !r_sel;
    assign o_flags.cnt_zero = (r_cnt == '0);
    assign o_flags.cnt_more = (r_cnt != i80_pkg::CNT_W'(1));
    assign o_flags.limit    = (r_reads >= i80_pkg::RD_W'(i80_pkg::READ_LIMIT));
    assign o_flags.no_dummy = !r_dummy;
    assign o_flags.out_free = out_free;

    assign o_out_valid        = r_out_valid;
    assign o_chip_select      = r_cs;
    assign o_data_not_command = r_dnc;
    assign o_strobe_res       = r_strobe;
    assign o_bus_out          = r_bus;
    assign o_wide_bus         = r_wide;
    assign o_read_value       = r_rd;
    assign o_status           = r_status;
    assign o_last             = r_last;

endmodule

/* src/i80_lcd_bus_master.sv */
// Top level of the 8080 display bus master; uses i80_pkg, i80_useq, i80_dp, assert_macros.svh.
// One microcode step per cycle unless a result-emitting step waits on a stalled output. Begin,
// end and unused codes give their result in the entry step; writes, bitmap, fill and reads
// first check selection, unselected items ending with a NOSEL status; fill then tests for a
// zero count, and reads test the read limit and send a dummy strobe first when one is armed.
// Sync active-low reset clears select flag (not o_chip_select), dummy, reads; colors 0/FFFF.
`include "assert_macros.svh"

module i80_lcd_bus_master (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_operation,
    input  logic [15:0]                 i_payload,
    input  logic [6:0]                  i_repeat_count,
    input  logic [7:0]                  i_bus_sample,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [15:0]                 i_cfg_wdata,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_chip_select,
    output logic                        o_data_not_command,
    output logic [1:0]                  o_strobe_res,
    output logic [15:0]                 o_bus_out,
    output logic                        o_wide_bus,
    output logic [7:0]                  o_read_value,
    output logic [1:0]                  o_status,
    output logic                        o_last
);

    i80_pkg::t_ctl   ctl;
    i80_pkg::t_flags flags;
    logic            busy;

    i80_useq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_flags     (flags),
        .o_busy      (busy),
        .o_ctl       (ctl)
    );

    i80_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .i_payload          (i_payload),
        .i_repeat_count     (i_repeat_count),
        .i_bus_sample       (i_bus_sample),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_out_stall        (i_out_stall),
        .o_flags            (flags),
        .o_out_valid        (o_out_valid),
        .o_chip_select      (o_chip_select),
        .o_data_not_command (o_data_not_command),
        .o_strobe_res       (o_strobe_res),
        .o_bus_out          (o_bus_out),
        .o_wide_bus         (o_wide_bus),
        .o_read_value       (o_read_value),
        .o_status           (o_status),
        .o_last             (o_last)
    );

    assign o_in_stall = busy;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMPL(a_dummy_not_last, i_clk, i_rst_n,
                 o_out_valid && o_strobe_res == i80_pkg::ST_DUMMY, !o_last)
    `ASSERT_IMPL(a_read_selected, i_clk, i_rst_n,
                 o_out_valid && o_strobe_res == i80_pkg::ST_READ, o_chip_select)
    `ASSERT_IMPL(a_nosel_released, i_clk, i_rst_n,
                 o_out_valid && o_status == i80_pkg::STAT_NOSEL,
                 !o_chip_select && o_strobe_res == i80_pkg::ST_NONE)

endmodule
